FILE: src/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, constants and state encoding for the spike-triggered
// covariance accumulator.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int MaxDimsPerFrame = 16;
  localparam int MaxWindowFrames = 8;
  localparam int MaxDims         = 128;
  localparam int CrossDepth      = MaxDims * (MaxDims + 1) / 2;
  localparam int HistDepth       = MaxWindowFrames * MaxDimsPerFrame;

  localparam int SlotW   = $clog2(MaxWindowFrames);
  localparam int PosW    = $clog2(MaxDimsPerFrame);
  localparam int HistAw  = $clog2(HistDepth);
  localparam int DimW    = $clog2(MaxDims);
  localparam int CrossAw = $clog2(CrossDepth);

  localparam int SumW   = 48;
  localparam int CrossW = 64;
  localparam int TotalW = 32;
  localparam int FrameW = 16;

  localparam logic [2:0] OP_PUSH       = 3'd0;
  localparam logic [2:0] OP_CLEAR      = 3'd1;
  localparam logic [2:0] OP_READ_SUM   = 3'd2;
  localparam logic [2:0] OP_READ_CROSS = 3'd3;
  localparam logic [2:0] OP_READ_TOTAL = 3'd4;

  localparam logic [1:0] REG_DIMS  = 2'd0;
  localparam logic [1:0] REG_START = 2'd1;
  localparam logic [1:0] REG_END   = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] stim_value;
    logic [7:0]         spike_count;
    logic               first_of_trial;
    logic               last_of_frame;
    logic [6:0]         row_index;
    logic [6:0]         col_index;
  } req_t;

  typedef struct packed {
    logic signed [63:0] read_value;
    logic               index_error;
  } rsp_t;

  typedef struct packed {
    logic [4:0]        dims_per_frame;
    logic signed [4:0] start_frame;
    logic [3:0]        end_frame;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH,
    ST_READ,
    ST_RESULT,
    ST_ROW_RD,
    ST_ROW_MUL,
    ST_ROW_SUM,
    ST_COL_RD,
    ST_COL_MUL,
    ST_COL_WR,
    ST_TOTAL
  } state_e;

  typedef struct packed {
    logic accept;
    logic push;
    logic clr_step;
    logic read_sel;
    logic row_phase;
    logic row_mul;
    logic row_sum;
    logic col_mul;
    logic col_wr;
    logic total_add;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic trigger;
    logic clr_last;
    logic row_last;
    logic col_last;
  } status_t;

endpackage

FILE: src/stc_ram.sv
// ----------------------------------------------------------------------------
// stc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stc_ram #(
  parameter int Width = 16,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: src/stc_ctrl.sv
// ----------------------------------------------------------------------------
// stc_ctrl
// Sequencer: request dispatch, store clearing sweep and the per-spike
// triangular update walk.
// ----------------------------------------------------------------------------
module stc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [2:0]       operation_i,
  input  stc_pkg::status_t status_i,
  output stc_pkg::cmd_t    cmd_o,
  output logic             busy_o
);
  import stc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          case (operation_i)
            OP_PUSH:       state_d = ST_PUSH;
            OP_CLEAR:      state_d = ST_CLEAR;
            OP_READ_SUM:   state_d = ST_READ;
            OP_READ_CROSS: state_d = ST_READ;
            OP_READ_TOTAL: state_d = ST_READ;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_PUSH:    state_d = status_i.trigger ? ST_ROW_RD : ST_IDLE;
      ST_READ:    state_d = ST_RESULT;
      ST_RESULT:  state_d = ST_IDLE;
      ST_ROW_RD:  state_d = ST_ROW_MUL;
      ST_ROW_MUL: state_d = ST_ROW_SUM;
      ST_ROW_SUM: state_d = ST_COL_RD;
      ST_COL_RD:  state_d = ST_COL_MUL;
      ST_COL_MUL: state_d = ST_COL_WR;
      ST_COL_WR: begin
        if (!status_i.col_last) state_d = ST_COL_RD;
        else if (status_i.row_last) state_d = ST_TOTAL;
        else state_d = ST_ROW_RD;
      end
      ST_TOTAL:   state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:    cmd_o.accept = start_i;
      ST_CLEAR:   cmd_o.clr_step = 1'b1;
      ST_PUSH:    cmd_o.push = 1'b1;
      ST_READ:    cmd_o.read_sel = 1'b1;
      ST_RESULT:  cmd_o.result = 1'b1;
      ST_ROW_RD:  cmd_o.row_phase = 1'b1;
      ST_ROW_MUL: cmd_o.row_mul = 1'b1;
      ST_ROW_SUM: cmd_o.row_sum = 1'b1;
      ST_COL_MUL: cmd_o.col_mul = 1'b1;
      ST_COL_WR:  cmd_o.col_wr = 1'b1;
      ST_TOTAL:   cmd_o.total_add = 1'b1;
      default:    cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: src/stc_dp.sv
// ----------------------------------------------------------------------------
// stc_dp
// Datapath: frame history, spike ring, sum and cross stores, window walk
// counters and saturating accumulation.
// ----------------------------------------------------------------------------
module stc_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stc_pkg::cfg_t cfg_i,
  input  stc_pkg::req_t req_i,
  input  stc_pkg::cmd_t cmd_i,
  output stc_pkg::status_t status_o,
  output stc_pkg::rsp_t result_o
);
  import stc_pkg::*;

  // Geometry
  logic signed [6:0] s7, e7, w7, l7, span7;
  logic [10:0]       dw;
  logic              geo_ok;
  logic [7:0]        nd;
  logic [SlotW-1:0]  lag;
  logic [3:0]        span;

  always_comb begin
    s7     = 7'(cfg_i.start_frame);
    e7     = $signed({3'b000, cfg_i.end_frame});
    w7     = e7 - s7 + 7'sd1;
    l7     = (s7 < 7'sd1) ? (7'sd1 - s7) : 7'sd0;
    span7  = e7 + l7;
    dw     = 11'(cfg_i.dims_per_frame) * 11'(w7[5:0]);
    geo_ok = (cfg_i.dims_per_frame != 5'd0) &&
             (cfg_i.dims_per_frame <= 5'(MaxDimsPerFrame)) &&
             (cfg_i.end_frame != 4'd0) && (s7 <= e7) &&
             (span7 <= 7'(MaxWindowFrames)) && (dw <= 11'(MaxDims));
    nd     = geo_ok ? dw[7:0] : 8'd0;
    lag    = l7[SlotW-1:0];
    span   = span7[3:0];
  end

  // Request and frame state
  req_t              req_q;
  logic [SlotW-1:0]  slot_q;
  logic [PosW:0]     pos_q;
  logic [FrameW-1:0] fn_q;
  logic [7:0]        ring_q [MaxWindowFrames];
  logic [7:0]        cnt_q;
  logic [SlotW-1:0]  first_q;
  logic [TotalW-1:0] total_q;
  logic [CrossAw-1:0] clr_q;

  logic [PosW:0]     pos_eff;
  logic [FrameW-1:0] fn_eff, fn_new;
  logic              hist_we;
  logic [7:0]        cand_cnt;
  logic              trigger;

  always_comb begin
    pos_eff  = req_q.first_of_trial ? '0 : pos_q;
    fn_eff   = req_q.first_of_trial ? '0 : fn_q;
    hist_we  = cmd_i.push && ((PosW+1)'(pos_eff) < (PosW+1)'(cfg_i.dims_per_frame)) &&
               (pos_eff < (PosW+1)'(MaxDimsPerFrame));
    fn_new   = (fn_eff == '1) ? fn_eff : fn_eff + 1'b1;
    cand_cnt = (lag == '0) ? req_q.spike_count : ring_q[slot_q - lag];
    trigger  = req_q.last_of_frame && (nd != 8'd0) &&
               (fn_new >= FrameW'(span)) && (cand_cnt != 8'd0);
  end

  // Walk counters
  logic [DimW-1:0]    i_q, j_q;
  logic [SlotW-1:0]   ki_q, kj_q;
  logic [PosW-1:0]    di_q, dj_q;
  logic [CrossAw-1:0] base_q;
  logic               di_wrap, dj_wrap;

  assign di_wrap = (5'(di_q) + 5'd1) == cfg_i.dims_per_frame;
  assign dj_wrap = (5'(dj_q) + 5'd1) == cfg_i.dims_per_frame;

  assign status_o.trigger  = trigger;
  assign status_o.clr_last = (clr_q == CrossAw'(CrossDepth - 1));
  assign status_o.row_last = (8'(i_q) + 8'd1) == nd;
  assign status_o.col_last = (j_q == i_q);

  // Memories
  logic [HistAw-1:0]        hist_waddr, hist_raddr;
  logic signed [15:0]       hist_rd;
  logic                     sum_we, cross_we;
  logic [DimW-1:0]          sum_addr;
  logic [CrossAw-1:0]       cross_addr, read_ix;
  logic signed [SumW-1:0]   sum_rd, sum_wd;
  logic signed [CrossW-1:0] cross_rd, cross_wd;

  assign hist_waddr = {slot_q, pos_eff[PosW-1:0]};
  assign hist_raddr = cmd_i.row_phase ? {first_q + ki_q, di_q} : {first_q + kj_q, dj_q};

  stc_ram #(.Width(16), .Depth(HistDepth)) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (req_q.stim_value),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rd)
  );

  logic [DimW-1:0] hi_ix, lo_ix;
  logic [2*DimW:0] tri_ix;

  always_comb begin
    hi_ix   = (req_q.row_index > req_q.col_index) ? req_q.row_index : req_q.col_index;
    lo_ix   = (req_q.row_index > req_q.col_index) ? req_q.col_index : req_q.row_index;
    tri_ix  = ((2*DimW+1)'(hi_ix) * (2*DimW+1)'({1'b0, hi_ix} + 1'b1)) >> 1;
    read_ix = CrossAw'(tri_ix + (2*DimW+1)'(lo_ix));
  end

  logic signed [23:0] ci_q;
  logic signed [39:0] prod_q;
  logic signed [SumW:0]   sum_ext;
  logic signed [CrossW:0] cross_ext;

  always_comb begin
    sum_ext   = {sum_rd[SumW-1], sum_rd} + (SumW+1)'(ci_q);
    cross_ext = {cross_rd[CrossW-1], cross_rd} + (CrossW+1)'(prod_q);
    if (sum_ext[SumW] != sum_ext[SumW-1]) begin
      sum_wd = sum_ext[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_wd = sum_ext[SumW-1:0];
    end
    if (cross_ext[CrossW] != cross_ext[CrossW-1]) begin
      cross_wd = cross_ext[CrossW] ? {1'b1, {(CrossW-1){1'b0}}} : {1'b0, {(CrossW-1){1'b1}}};
    end else begin
      cross_wd = cross_ext[CrossW-1:0];
    end
  end

  always_comb begin
    if (cmd_i.clr_step) begin
      sum_addr   = clr_q[DimW-1:0];
      cross_addr = clr_q;
    end else if (cmd_i.read_sel) begin
      sum_addr   = req_q.row_index;
      cross_addr = read_ix;
    end else begin
      sum_addr   = i_q;
      cross_addr = base_q + CrossAw'(j_q);
    end
    sum_we   = (cmd_i.clr_step && (clr_q < CrossAw'(MaxDims))) || cmd_i.row_sum;
    cross_we = cmd_i.clr_step || cmd_i.col_wr;
  end

  stc_ram #(.Width(SumW), .Depth(MaxDims)) u_sum (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_addr),
    .wdata_i (cmd_i.clr_step ? '0 : sum_wd),
    .raddr_i (sum_addr),
    .rdata_o (sum_rd)
  );

  stc_ram #(.Width(CrossW), .Depth(CrossDepth)) u_cross (
    .clk_i   (clk_i),
    .we_i    (cross_we),
    .waddr_i (cross_addr),
    .wdata_i (cmd_i.clr_step ? '0 : cross_wd),
    .raddr_i (cross_addr),
    .rdata_o (cross_rd)
  );

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) req_q <= req_i;
    if (cmd_i.push && trigger) begin
      cnt_q   <= cand_cnt;
      first_q <= slot_q - SlotW'(span - 4'd1);
    end
    if (cmd_i.row_mul) ci_q <= 24'($signed({1'b0, cnt_q})) * 24'(hist_rd);
    if (cmd_i.col_mul) prod_q <= ci_q * hist_rd;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      pos_q   <= '0;
      fn_q    <= '0;
      ring_q  <= '{default: '0};
      total_q <= '0;
      clr_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      ki_q    <= '0;
      kj_q    <= '0;
      di_q    <= '0;
      dj_q    <= '0;
      base_q  <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        total_q <= '0;
        clr_q   <= status_o.clr_last ? '0 : clr_q + 1'b1;
      end
      if (cmd_i.push) begin
        if (req_q.last_of_frame) begin
          ring_q[slot_q] <= req_q.spike_count;
          fn_q   <= fn_new;
          slot_q <= slot_q + 1'b1;
          pos_q  <= '0;
        end else begin
          fn_q  <= fn_eff;
          pos_q <= hist_we ? pos_eff + 1'b1 : pos_eff;
        end
        if (trigger) begin
          i_q    <= '0;
          j_q    <= '0;
          ki_q   <= '0;
          kj_q   <= '0;
          di_q   <= '0;
          dj_q   <= '0;
          base_q <= '0;
        end
      end
      if (cmd_i.col_wr) begin
        if (status_o.col_last) begin
          j_q    <= '0;
          kj_q   <= '0;
          dj_q   <= '0;
          base_q <= base_q + CrossAw'(i_q) + 1'b1;
          i_q    <= i_q + 1'b1;
          if (di_wrap) begin
            di_q <= '0;
            ki_q <= ki_q + 1'b1;
          end else begin
            di_q <= di_q + 1'b1;
          end
        end else begin
          j_q <= j_q + 1'b1;
          if (dj_wrap) begin
            dj_q <= '0;
            kj_q <= kj_q + 1'b1;
          end else begin
            dj_q <= dj_q + 1'b1;
          end
        end
      end
      if (cmd_i.total_add) begin
        total_q <= ((TotalW+1)'(total_q) + (TotalW+1)'(cnt_q) > (TotalW+1)'({TotalW{1'b1}})) ?
                   '1 : total_q + TotalW'(cnt_q);
      end
    end
  end

  // Read response
  logic row_ok, col_ok;

  assign row_ok = 8'(req_q.row_index) < nd;
  assign col_ok = 8'(req_q.col_index) < nd;

  always_comb begin
    result_o = '0;
    case (req_q.operation)
      OP_READ_SUM: begin
        if (row_ok) result_o.read_value = 64'(sum_rd);
        else result_o.index_error = 1'b1;
      end
      OP_READ_CROSS: begin
        if (row_ok && col_ok) result_o.read_value = cross_rd;
        else result_o.index_error = 1'b1;
      end
      OP_READ_TOTAL: result_o.read_value = $signed({32'd0, total_q});
      default: result_o = '0;
    endcase
  end

endmodule

FILE: src/spike_triggered_covariance_accumulator.sv
// Push: push state, then idle or the walk. Read: read state, then result strobe.
// Clear: sweep of the sum and cross stores. A push that completes a spiking
// window then runs the read-modify-write walk over the single-port cross store.
// After reset the block sweeps the sum and cross stores with busy high;
// configuration writes are taken throughout.
// Results carry no back-pressure: each strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
// spike_triggered_covariance_accumulator
// Top level: APB configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
module spike_triggered_covariance_accumulator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  stc_pkg::req_t  req_i,
  output logic           busy_o,
  output logic           result_valid_o,
  output stc_pkg::rsp_t  result_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import stc_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dims_per_frame <= 5'd3;
      cfg_q.start_frame    <= 5'sd1;
      cfg_q.end_frame      <= 4'd1;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_DIMS:  cfg_q.dims_per_frame <= pwdata[4:0];
        REG_START: cfg_q.start_frame    <= pwdata[4:0];
        REG_END:   cfg_q.end_frame      <= pwdata[3:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DIMS:  prdata = 32'(cfg_q.dims_per_frame);
      REG_START: prdata = 32'(cfg_q.start_frame);
      REG_END:   prdata = 32'(cfg_q.end_frame);
      default:   prdata = '0;
    endcase
  end

  stc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (req_i.operation),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  stc_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o)
  );

  assign result_valid_o = cmd.result;

endmodule

FILE: tb/stc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stc_checker
// Watches the request, result and register ports of the spike-triggered
// covariance accumulator, keeps its own copy of the frame history and of
// the accumulators, and compares every read result with the value it
// predicts. Reports the failure, outstanding read and checked counts to the top.
// ----------------------------------------------------------------------------
module stc_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  stc_pkg::req_t     req_i,
  input  logic              result_valid_i,
  input  stc_pkg::rsp_t     result_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [3:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  output int                fail_count_o,
  output int                outstanding_o,
  output int                checked_o
);
  import stc_pkg::*;

  localparam longint SumMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SumMin = -SumMax - 1;

  logic [4:0]        dims_q;
  logic signed [4:0] start_q;
  logic [3:0]        end_q;

  logic signed [15:0] history [MaxWindowFrames][MaxDimsPerFrame];
  logic [7:0]         count_ring [MaxWindowFrames];
  int                 frame_num;
  int                 elem_pos;
  int                 slot;
  longint             sums [MaxDims];
  longint             cross_sum [CrossDepth];
  logic [31:0]        total;

  rsp_t expected_reads[$];
  int   fails;
  int   checked;

  function automatic int window_dims(output int win, output int lag);
    int s;
    int e;
    int d;
    s = start_q;
    e = end_q;
    d = dims_q;
    win = 0;
    lag = 0;
    if (d < 1 || d > MaxDimsPerFrame || e < 1 || s > e) return 0;
    win = e - s + 1;
    lag = (s < 1) ? 1 - s : 0;
    if (e + lag > MaxWindowFrames) return 0;
    if (d * win > MaxDims) return 0;
    return d * win;
  endfunction

  function automatic int slot_back(int back);
    return (slot + MaxWindowFrames - (back % MaxWindowFrames)) % MaxWindowFrames;
  endfunction

  function automatic longint sat_cross(longint a, longint b);
    longint r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63])
      r = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    return r;
  endfunction

  task automatic fold_window();
    int         win;
    int         lag;
    int         nd;
    int         span;
    int         first;
    int         sl;
    int         ix;
    int         dims;
    longint     vec [MaxDims];
    longint     ci;
    longint     s;
    logic [7:0] cnt;
    logic [32:0] t;
    nd = window_dims(win, lag);
    if (nd == 0) return;
    span = end_q + lag;
    if (frame_num < span) return;
    cnt = count_ring[slot_back(lag)];
    if (cnt == 0) return;
    dims = dims_q;
    first = slot_back(span - 1);
    for (int k = 0; k < win; k++) begin
      sl = (first + k) % MaxWindowFrames;
      for (int d = 0; d < dims; d++) vec[k * dims + d] = history[sl][d];
    end
    for (int i = 0; i < nd; i++) begin
      ci = longint'(cnt) * vec[i];
      s = sums[i] + ci;
      if (s > SumMax) s = SumMax;
      if (s < SumMin) s = SumMin;
      sums[i] = s;
      for (int j = 0; j <= i; j++) begin
        ix = i * (i + 1) / 2 + j;
        cross_sum[ix] = sat_cross(cross_sum[ix], ci * vec[j]);
      end
    end
    t = {1'b0, total} + cnt;
    total = t[32] ? '1 : t[31:0];
  endtask

  task automatic apply_push(req_t r);
    if (r.first_of_trial) begin
      frame_num = 0;
      elem_pos = 0;
    end
    if (elem_pos < dims_q && elem_pos < MaxDimsPerFrame) begin
      history[slot][elem_pos] = r.stim_value;
      elem_pos++;
    end
    if (r.last_of_frame) begin
      count_ring[slot] = r.spike_count;
      if (frame_num < 65535) frame_num++;
      fold_window();
      slot = (slot + 1) % MaxWindowFrames;
      elem_pos = 0;
    end
  endtask

  function automatic rsp_t read_back(req_t r);
    int   win;
    int   lag;
    int   nd;
    int   hi;
    int   lo;
    rsp_t e;
    e = '0;
    nd = window_dims(win, lag);
    case (r.operation)
      OP_READ_SUM: begin
        if (r.row_index < nd) e.read_value = sums[r.row_index];
        else e.index_error = 1'b1;
      end
      OP_READ_CROSS: begin
        if (r.row_index < nd && r.col_index < nd) begin
          hi = (r.row_index > r.col_index) ? r.row_index : r.col_index;
          lo = (r.row_index > r.col_index) ? r.col_index : r.row_index;
          e.read_value = cross_sum[hi * (hi + 1) / 2 + lo];
        end else begin
          e.index_error = 1'b1;
        end
      end
      default: e.read_value = {32'b0, total};
    endcase
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      dims_q = 5'd3;
      start_q = 5'sd1;
      end_q = 4'd1;
      foreach (count_ring[i]) count_ring[i] = '0;
      foreach (sums[i]) sums[i] = 0;
      foreach (cross_sum[i]) cross_sum[i] = 0;
      frame_num = 0;
      elem_pos = 0;
      slot = 0;
      total = '0;
      fails = 0;
      checked = 0;
      expected_reads.delete();
    end else begin
      if (result_valid_i) begin
        if (expected_reads.size() == 0) begin
          $display("%0t result with no read pending: value %0d, index_error %0b",
                   $time, result_i.read_value, result_i.index_error);
          fails++;
        end else begin
          e = expected_reads.pop_front();
          checked++;
          if (result_i.read_value !== e.read_value) begin
            $display("%0t read_value mismatch: expected %0d, got %0d",
                     $time, e.read_value, result_i.read_value);
            fails++;
          end
          if (result_i.index_error !== e.index_error) begin
            $display("%0t index_error mismatch: expected %0b, got %0b",
                     $time, e.index_error, result_i.index_error);
            fails++;
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_DIMS:  dims_q = pwdata_i[4:0];
          REG_START: start_q = pwdata_i[4:0];
          REG_END:   end_q = pwdata_i[3:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        case (req_i.operation)
          OP_PUSH: apply_push(req_i);
          OP_CLEAR: begin
            foreach (sums[i]) sums[i] = 0;
            foreach (cross_sum[i]) cross_sum[i] = 0;
            total = '0;
          end
          OP_READ_SUM, OP_READ_CROSS, OP_READ_TOTAL:
            expected_reads.push_back(read_back(req_i));
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    outstanding_o <= expected_reads.size();
    checked_o <= checked;
  end

endmodule

FILE: tb/tb_spike_triggered_covariance_accumulator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spike_triggered_covariance_accumulator
// Drives frame pushes, clears and reads into the accumulator under a range
// of window settings, valid and invalid, with random request gaps; the
// checker beside the block predicts and compares every read result.
// ----------------------------------------------------------------------------
module tb_spike_triggered_covariance_accumulator;
  import stc_pkg::*;

  localparam int CycleLimit = 3_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  req_t        req_i;
  logic        busy_o;
  logic        result_valid_o;
  rsp_t        result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int outstanding;
  int checked;
  int cycles;
  int requests;
  int spikes;
  int settings;
  int idle_pct;

  int cfg_dims;
  int cfg_start;
  int cfg_end;
  bit written [MaxWindowFrames][MaxDimsPerFrame];
  int m_slot;
  int m_pos;

  spike_triggered_covariance_accumulator dut (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  stc_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_i,
    .result_valid_i(result_valid_o), .result_i(result_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .outstanding_o(outstanding), .checked_o(checked)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("spike_triggered_covariance_accumulator verification failed");
      $finish;
    end
  end

  function automatic int window_nd();
    int lag;
    int win;
    if (cfg_dims < 1 || cfg_dims > MaxDimsPerFrame || cfg_end < 1 || cfg_start > cfg_end)
      return 0;
    win = cfg_end - cfg_start + 1;
    lag = (cfg_start < 1) ? 1 - cfg_start : 0;
    if (cfg_end + lag > MaxWindowFrames || cfg_dims * win > MaxDims) return 0;
    return cfg_dims * win;
  endfunction

  function automatic bit rest_written(int from);
    int top;
    top = (cfg_dims < MaxDimsPerFrame) ? cfg_dims : MaxDimsPerFrame;
    for (int q = from; q < top; q++) if (!written[m_slot][q]) return 0;
    return 1;
  endfunction

  task automatic send(req_t r);
    if (r.operation == OP_PUSH) begin
      if (r.first_of_trial) m_pos = 0;
      if (m_pos < cfg_dims && m_pos < MaxDimsPerFrame) begin
        written[m_slot][m_pos] = 1'b1;
        m_pos++;
      end
      if (r.last_of_frame) begin
        m_slot = (m_slot + 1) % MaxWindowFrames;
        m_pos = 0;
        if (r.spike_count != 0) spikes++;
      end
    end
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    requests++;
    idle_pct = (requests < 300) ? 13 : (requests < 600) ? 72 : 0;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic req_t noise_req(logic [2:0] op);
    req_t        r;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    r.operation = op;
    return r;
  endfunction

  task automatic push(logic [15:0] value, logic [7:0] count, bit first, bit last);
    req_t r;
    r = noise_req(OP_PUSH);
    r.stim_value = value;
    r.spike_count = count;
    r.first_of_trial = first;
    r.last_of_frame = last;
    send(r);
  endtask

  task automatic read(logic [2:0] op, logic [6:0] row, logic [6:0] col);
    req_t r;
    r = noise_req(op);
    r.row_index = row;
    r.col_index = col;
    send(r);
  endtask

  task automatic wait_quiet();
    start_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (2) @(posedge clk_i);
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value) & 32'h1F;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_DIMS:  cfg_dims = value & 31;
      REG_START: cfg_start = ((value & 31) >= 16) ? (value & 31) - 32 : (value & 31);
      default:   cfg_end = value & 15;
    endcase
  endtask

  task automatic configure(int dims, int first, int last);
    wait_quiet();
    write_reg(REG_END, last);
    write_reg(REG_START, first);
    write_reg(REG_DIMS, dims);
    settings++;
    read(OP_CLEAR, 0, 0);
  endtask

  task automatic push_frame(int spike_pct, bit new_trial, int noise);
    int   n;
    int   i;
    int   p;
    int   stored_next;
    int   eff;
    bit   lst;
    bit   first;
    logic [7:0] cnt;
    eff = (cfg_dims < 1) ? 1 : cfg_dims;
    n = eff;
    if (noise == 1 && eff > 1) n = $urandom_range(1, eff - 1);
    if (noise == 2) n = eff + $urandom_range(1, 3);
    i = 0;
    lst = 0;
    while (!lst) begin
      first = (i == 0) && new_trial;
      p = first ? 0 : m_pos;
      stored_next = (p < cfg_dims && p < MaxDimsPerFrame) ? p + 1 : p;
      lst = (i >= n - 1) && rest_written(stored_next);
      cnt = 8'($urandom);
      if (lst) begin
        if ($urandom_range(99) < spike_pct)
          cnt = ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(1, 255));
        else
          cnt = '0;
      end
      push(16'($urandom), cnt, first, lst);
      i++;
    end
  endtask

  task automatic random_phase(int budget);
    int nd;
    int target;
    int pick;
    int spike_pct;
    nd = window_nd();
    spike_pct = (nd > 64) ? 6 : 20;
    target = requests + budget;
    push_frame(spike_pct, 1'b1, 0);
    while (requests < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        push_frame(spike_pct, $urandom_range(19) == 0, 0);
      end else if (pick < 66) begin
        push_frame(spike_pct, $urandom_range(1) == 0, $urandom_range(1, 2));
      end else if (pick < 90) begin
        read($urandom_range(1) ? OP_READ_SUM : ($urandom_range(2) ? OP_READ_CROSS :
             OP_READ_TOTAL),
             ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(0, nd + 1)),
             ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(0, nd + 1)));
      end else if (pick < 96) begin
        read(3'($urandom_range(5, 7)), 7'($urandom), 7'($urandom));
      end else if (pick < 98) begin
        push(16'($urandom), 8'($urandom), 1'b1, 1'b0);
      end else begin
        read(OP_CLEAR, 7'($urandom), 7'($urandom));
      end
    end
  endtask

  initial begin
    int d;
    int s;
    int e;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    requests = 0;
    spikes = 0;
    settings = 1;
    idle_pct = 13;
    cfg_dims = 3;
    cfg_start = 1;
    cfg_end = 1;
    m_slot = 0;
    m_pos = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push(16'sh7FFF, 8'd0, 1'b1, 1'b0);
    push(16'sh8000, 8'd0, 1'b0, 1'b0);
    push(16'h0000, 8'd255, 1'b0, 1'b1);
    push(16'sh8000, 8'd0, 1'b0, 1'b0);
    push(16'sh8000, 8'd0, 1'b0, 1'b0);
    push(16'sh8000, 8'd1, 1'b0, 1'b1);
    read(OP_READ_SUM, 0, 0);
    read(OP_READ_SUM, 2, 0);
    read(OP_READ_SUM, 3, 0);
    read(OP_READ_SUM, 127, 0);
    read(OP_READ_CROSS, 2, 0);
    read(OP_READ_CROSS, 0, 2);
    read(OP_READ_CROSS, 2, 2);
    read(OP_READ_CROSS, 3, 0);
    read(OP_READ_CROSS, 127, 127);
    read(OP_READ_TOTAL, 0, 0);
    start_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    read(3'd5, 0, 0);
    read(3'd6, 0, 0);
    read(3'd7, 0, 0);
    read(OP_CLEAR, 0, 0);
    read(OP_READ_TOTAL, 0, 0);
    read(OP_READ_CROSS, 1, 0);

    configure(16, -6, 1);
    random_phase(200);
    configure(1, 8, 8);
    random_phase(60);
    configure(0, 1, 1);
    random_phase(30);
    configure(31, 5, 2);
    random_phase(30);
    configure(2, 0, 8);
    random_phase(30);
    while (requests < 850) begin
      do begin
        d = $urandom_range(1, 16);
        e = $urandom_range(1, 8);
        s = $urandom_range(0, 14) - 6;
        cfg_dims = d;
        cfg_start = s;
        cfg_end = e;
      end while (!((window_nd() > 0 && window_nd() <= 48) ||
                   (window_nd() == 0 && $urandom_range(9) == 0)));
      configure(d, s, e);
      random_phase(50 + 4 * d);
    end

    wait_quiet();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d requests under %0d register settings with %0d spiking frames;",
             requests, settings, spikes);
    $display("%0d read results compared against the prediction.", checked);
    if (fail_count == 0) begin
      $display("spike_triggered_covariance_accumulator verification clean");
    end else begin
      $display("spike_triggered_covariance_accumulator verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/stc_pkg.sv
src/stc_ram.sv
src/stc_ctrl.sv
src/stc_dp.sv
src/spike_triggered_covariance_accumulator.sv
tb/stc_checker.sv
tb/tb_spike_triggered_covariance_accumulator.sv
